FILE: rtl/rcfr_pkg.sv
package rcfr_pkg;

   localparam int FREQ_W         = 34;
   localparam int BODY_DEPTH_DEF = 16;
   localparam int OUT_CNT_W      = 4;
   localparam int CSR_IDX_W      = 4;
   localparam int BCD_DIGITS     = 10;

   localparam logic [7:0] BYTE_PREAMBLE = 8'hFE;
   localparam logic [7:0] BYTE_EOM      = 8'hFD;
   localparam logic [7:0] BYTE_ACK      = 8'hFB;
   localparam logic [7:0] BYTE_NAK      = 8'hFA;
   localparam logic [7:0] OWN_ADDR_DEF  = 8'h94;
   localparam logic [7:0] CTRL_ADDR_DEF = 8'hE0;

   localparam logic [7:0] CMD_READ_FREQ  = 8'h03;
   localparam logic [7:0] CMD_READ_MODE  = 8'h04;
   localparam logic [7:0] CMD_WRITE_FREQ = 8'h05;
   localparam logic [7:0] CMD_WRITE_MODE = 8'h06;
   localparam logic [7:0] CMD_VFO        = 8'h07;
   localparam logic [7:0] CMD_SPLIT      = 8'h0F;
   localparam logic [7:0] CMD_MISC       = 8'h1A;
   localparam logic [7:0] CMD_PTT        = 8'h1C;
   localparam logic [7:0] SUB_LEVEL      = 8'h03;
   localparam logic [7:0] SUB_DATA_MODE  = 8'h06;
   localparam logic [7:0] SUB_PTT        = 8'h00;
   localparam logic [7:0] LEVEL_VALUE    = 8'd34;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDR   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_LOWER = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_UPPER = CSR_IDX_W'(3);

   localparam logic [FREQ_W-1:0] FREQ_LOWER_DEF = '0;
   localparam logic [FREQ_W-1:0] FREQ_UPPER_DEF = FREQ_W'(64'd9999999999);

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CAPTURE,
      OP_START,
      OP_STORE,
      OP_EXEC,
      OP_FW_STEP,
      OP_BCD_STEP,
      OP_CLAMP_LO,
      OP_CLAMP_HI,
      OP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type            op;
      logic [OUT_CNT_W-1:0] emit_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic                 rx_fe;
      logic                 rx_fd;
      logic                 rx_own;
      logic                 body_last;
      logic                 loop_op;
      logic                 write_freq;
      logic                 step_zero;
      logic                 out_free;
      logic [OUT_CNT_W-1:0] out_total;
   } dp_stat_type;

endpackage

FILE: rtl/rcfr_ctl.sv
module rcfr_ctl
   import rcfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PARSE,
      S_EXEC,
      S_LOOP,
      S_CLAMP_LO,
      S_CLAMP_HI,
      S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_PRE2,
      PH_ADDR,
      PH_CTRL,
      PH_BODY
   } phase_type;

   state_type            state_ff;
   phase_type            phase_ff;
   logic [OUT_CNT_W-1:0] emit_ff;
   logic                 accept;
   logic                 emit_last;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign emit_last = (emit_ff == stat.out_total - OUT_CNT_W'(1));

   always_comb begin
      cmd.op       = OP_IDLE;
      cmd.emit_idx = emit_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) cmd.op = OP_CAPTURE;
         end
         S_PARSE: begin
            if (phase_ff == PH_CTRL) cmd.op = OP_START;
            else if (phase_ff == PH_BODY && !stat.rx_fd) cmd.op = OP_STORE;
         end
         S_EXEC:     cmd.op = OP_EXEC;
         S_LOOP: begin
            if (!stat.step_zero) cmd.op = stat.write_freq ? OP_FW_STEP : OP_BCD_STEP;
         end
         S_CLAMP_LO: cmd.op = OP_CLAMP_LO;
         S_CLAMP_HI: cmd.op = OP_CLAMP_HI;
         S_EMIT: begin
            if (stat.out_total != '0 && stat.out_free) cmd.op = OP_LOAD;
         end
         default:    cmd.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_HUNT;
         emit_ff  <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               emit_ff <= '0;
               if (accept) state_ff <= S_PARSE;
            end
            S_PARSE: begin
               state_ff <= (phase_ff == PH_BODY && stat.rx_fd) ? S_EXEC : S_EMIT;
               case (phase_ff)
                  PH_HUNT: phase_ff <= stat.rx_fe ? PH_PRE2 : PH_HUNT;
                  PH_PRE2: phase_ff <= stat.rx_fe ? PH_ADDR : PH_HUNT;
                  PH_ADDR: phase_ff <= stat.rx_own ? PH_CTRL : PH_HUNT;
                  PH_CTRL: phase_ff <= PH_BODY;
                  PH_BODY: begin
                     if (stat.rx_fd || stat.body_last) phase_ff <= PH_HUNT;
                  end
                  default: phase_ff <= PH_HUNT;
               endcase
            end
            S_EXEC:     state_ff <= stat.loop_op ? S_LOOP : S_EMIT;
            S_LOOP: begin
               if (stat.step_zero) state_ff <= stat.write_freq ? S_CLAMP_LO : S_EMIT;
            end
            S_CLAMP_LO: state_ff <= S_CLAMP_HI;
            S_CLAMP_HI: state_ff <= S_EMIT;
            S_EMIT: begin
               if (stat.out_total == '0) begin
                  state_ff <= S_IDLE;
               end else if (stat.out_free) begin
                  if (emit_last) state_ff <= S_IDLE;
                  else emit_ff <= emit_ff + OUT_CNT_W'(1);
               end
            end
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

   // a command runs only after its frame has closed
   a_exec_closes_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOP) |-> (phase_ff == PH_HUNT))
      else $error("command loop with frame still open");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |-> stat.out_free)
      else $error("output beat loaded over a held beat");

   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |-> (emit_ff < stat.out_total))
      else $error("emit index past end of run");

   a_accept_parses: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_PARSE))
      else $error("accepted beat not parsed");

endmodule

FILE: rtl/rcfr_dp.sv
module rcfr_dp
   import rcfr_pkg::*;
#(
   parameter int BODY_DEPTH = BODY_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_run,
   output logic                 rsp_is_echo,
   output logic [FREQ_W-1:0]    rsp_freq_now,
   output logic [2:0]           rsp_mode_now,
   output logic                 rsp_ptt_on,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FREQ_W-1:0]    csr_wdata
);

   localparam int CW = $clog2(BODY_DEPTH + 1);
   localparam int AW = $clog2(BODY_DEPTH);
   localparam int SW = $clog2(FREQ_W + 1);

   typedef enum logic [3:0] {
      RPL_NONE,
      RPL_ACK,
      RPL_NAK,
      RPL_FREQ,
      RPL_MODE,
      RPL_SPLIT,
      RPL_LEVEL,
      RPL_DMODE,
      RPL_PTT
   } reply_type;

   // config
   logic [7:0]        own_ff;
   logic              echo_ff;
   logic [FREQ_W-1:0] lower_ff;
   logic [FREQ_W-1:0] upper_ff;

   // held state
   logic [7:0]        ca_ff;
   logic [CW-1:0]     count_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic [2:0]        mode_ff;
   logic              tx_ff;
   reply_type         reply_ff;
   logic [SW-1:0]     step_ff;
   logic              rsp_valid_ff;

   // payload
   logic [7:0]                rx_ff;
   logic [7:0]                b0_ff, b1_ff, b2_ff;
   logic [7:0]                body_mem [BODY_DEPTH];
   logic [7:0]                rd_ff;
   logic [FREQ_W-1:0]         acc_ff;
   logic [FREQ_W-1:0]         bin_ff;
   logic [4*BCD_DIGITS-1:0]   bcd_ff;
   logic [7:0]                out_byte_ff;
   logic                      out_last_ff, out_echo_ff;
   logic [FREQ_W-1:0]         out_freq_ff;
   logic [2:0]                out_mode_ff;
   logic                      out_ptt_ff;

   // exec decode
   logic [CW-1:0]     len;
   logic              body_empty;
   logic [7:0]        b1v, b2v;
   logic              len0, len1, len2, len_long;
   logic [7:0]        sel_map;
   reply_type         reply_in;
   logic [SW-1:0]     step_init;
   logic [AW-1:0]     rd_addr;
   logic [4*BCD_DIGITS-1:0] bcd_adj;
   logic [7:0]        digit_pair;
   logic [FREQ_W-1:0] acc_in;

   // emit
   logic [OUT_CNT_W-1:0] ndata;
   logic [OUT_CNT_W-1:0] pos;
   logic [2:0]           dj;
   logic [7:0]           data_byte;
   logic [7:0]           byte_in;
   logic                 is_echo_in;

   assign csr_ready  = 1'b1;
   assign body_empty = (count_ff == '0);
   assign len        = count_ff - CW'(1);
   assign len0       = (count_ff == CW'(1));
   assign len1       = (count_ff == CW'(2));
   assign len2       = (count_ff == CW'(3));
   assign len_long   = (count_ff > CW'(6));
   assign b1v        = (count_ff > CW'(1)) ? b1_ff : 8'h00;
   assign b2v        = (count_ff > CW'(2)) ? b2_ff : 8'h00;

   always_comb begin
      if (b1v == 8'd4)      sel_map = 8'd5;
      else if (b1v == 8'd7) sel_map = 8'd4;
      else                  sel_map = b1v;
   end

   always_comb begin
      reply_in = RPL_NONE;
      if (!body_empty) begin
         case (b0_ff)
            CMD_READ_FREQ:  reply_in = RPL_FREQ;
            CMD_READ_MODE:  reply_in = RPL_MODE;
            CMD_WRITE_FREQ: reply_in = RPL_ACK;
            CMD_WRITE_MODE: reply_in = ((len1 || len2) && sel_map < 8'd5) ? RPL_ACK : RPL_NAK;
            CMD_VFO:        reply_in = RPL_ACK;
            CMD_SPLIT: begin
               if (len0)              reply_in = RPL_SPLIT;
               else if (b1v == 8'h00) reply_in = RPL_ACK;
               else                   reply_in = RPL_NAK;
            end
            CMD_MISC: begin
               if (b1v == SUB_LEVEL)          reply_in = len1 ? RPL_LEVEL : RPL_ACK;
               else if (b1v == SUB_DATA_MODE) reply_in = len1 ? RPL_DMODE : RPL_ACK;
            end
            CMD_PTT: begin
               if (b1v == SUB_PTT) reply_in = len1 ? RPL_PTT : RPL_ACK;
            end
            default:        reply_in = RPL_NONE;
         endcase
      end
   end

   // loop length: 34 shifts for a frequency read, one step per data byte, up to 5, for a write
   always_comb begin
      step_init = '0;
      if (!body_empty && b0_ff == CMD_READ_FREQ) step_init = SW'(FREQ_W);
      else if (!body_empty && b0_ff == CMD_WRITE_FREQ && !len_long) step_init = SW'(len);
   end

   assign rd_addr = (cmd.op == OP_EXEC) ? AW'(len) : AW'(step_ff - SW'(1));

   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                         : bcd_ff[4*d +: 4];
      end
   end

   // nibbles above 9 are taken as is
   assign digit_pair = {1'b0, rd_ff[7:4], 3'b000} + {3'b000, rd_ff[7:4], 1'b0}
                     + {4'h0, rd_ff[3:0]};
   assign acc_in = (acc_ff << 6) + (acc_ff << 5) + (acc_ff << 2)
                 + {{(FREQ_W-8){1'b0}}, digit_pair};

   always_comb begin
      case (reply_ff)
         RPL_ACK, RPL_NAK: ndata = OUT_CNT_W'(1);
         RPL_FREQ:         ndata = OUT_CNT_W'(6);
         RPL_MODE:         ndata = OUT_CNT_W'(3);
         RPL_SPLIT:        ndata = OUT_CNT_W'(2);
         RPL_LEVEL:        ndata = OUT_CNT_W'(3);
         RPL_DMODE:        ndata = OUT_CNT_W'(4);
         RPL_PTT:          ndata = OUT_CNT_W'(3);
         default:          ndata = '0;
      endcase
   end

   assign pos = cmd.emit_idx - {{(OUT_CNT_W-1){1'b0}}, echo_ff};
   assign dj  = 3'(pos - OUT_CNT_W'(4));

   always_comb begin
      data_byte = 8'h00;
      case (reply_ff)
         RPL_ACK: data_byte = BYTE_ACK;
         RPL_NAK: data_byte = BYTE_NAK;
         RPL_FREQ: begin
            case (dj)
               3'd0:    data_byte = CMD_READ_FREQ;
               3'd1:    data_byte = bcd_ff[7:0];
               3'd2:    data_byte = bcd_ff[15:8];
               3'd3:    data_byte = bcd_ff[23:16];
               3'd4:    data_byte = bcd_ff[31:24];
               default: data_byte = bcd_ff[39:32];
            endcase
         end
         RPL_MODE: begin
            case (dj)
               3'd0:    data_byte = CMD_READ_MODE;
               3'd1:    data_byte = (mode_ff == 3'd4) ? 8'd7 : {5'b0, mode_ff};
               default: data_byte = 8'h01;
            endcase
         end
         RPL_SPLIT: data_byte = (dj == 3'd0) ? CMD_SPLIT : 8'h00;
         RPL_LEVEL: begin
            case (dj)
               3'd0:    data_byte = CMD_MISC;
               3'd1:    data_byte = SUB_LEVEL;
               default: data_byte = LEVEL_VALUE;
            endcase
         end
         RPL_DMODE: begin
            case (dj)
               3'd0:    data_byte = CMD_MISC;
               3'd1:    data_byte = SUB_DATA_MODE;
               default: data_byte = 8'h00;
            endcase
         end
         RPL_PTT: begin
            case (dj)
               3'd0:    data_byte = CMD_PTT;
               3'd1:    data_byte = SUB_PTT;
               default: data_byte = {7'b0, tx_ff};
            endcase
         end
         default: data_byte = 8'h00;
      endcase
   end

   always_comb begin
      is_echo_in = echo_ff && (cmd.emit_idx == '0);
      if (is_echo_in)                              byte_in = rx_ff;
      else if (pos == OUT_CNT_W'(0) || pos == OUT_CNT_W'(1)) byte_in = BYTE_PREAMBLE;
      else if (pos == OUT_CNT_W'(2))               byte_in = ca_ff;
      else if (pos == OUT_CNT_W'(3))               byte_in = own_ff;
      else if (pos == OUT_CNT_W'(4) + ndata)       byte_in = BYTE_EOM;
      else                                         byte_in = data_byte;
   end

   always_comb begin
      stat.rx_fe      = (rx_ff == BYTE_PREAMBLE);
      stat.rx_fd      = (rx_ff == BYTE_EOM);
      stat.rx_own     = (rx_ff == own_ff);
      stat.body_last  = (count_ff == CW'(BODY_DEPTH - 1));
      stat.write_freq = (b0_ff == CMD_WRITE_FREQ);
      stat.loop_op    = !body_empty && (b0_ff == CMD_READ_FREQ || b0_ff == CMD_WRITE_FREQ);
      stat.step_zero  = (step_ff == '0);
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
      stat.out_total  = {{(OUT_CNT_W-1){1'b0}}, echo_ff}
                      + ((reply_ff != RPL_NONE) ? OUT_CNT_W'(5) + ndata : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff       <= OWN_ADDR_DEF;
         echo_ff      <= 1'b1;
         lower_ff     <= FREQ_LOWER_DEF;
         upper_ff     <= FREQ_UPPER_DEF;
         ca_ff        <= CTRL_ADDR_DEF;
         count_ff     <= '0;
         freq_ff      <= FREQ_LOWER_DEF;
         mode_ff      <= 3'd0;
         tx_ff        <= 1'b0;
         reply_ff     <= RPL_NONE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_OWN_ADDR:   own_ff   <= csr_wdata[7:0];
               CSR_ECHO:       echo_ff  <= csr_wdata[0];
               CSR_FREQ_LOWER: lower_ff <= csr_wdata;
               CSR_FREQ_UPPER: upper_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (cmd.op)
            OP_CAPTURE: reply_ff <= RPL_NONE;
            OP_START: begin
               ca_ff    <= rx_ff;
               count_ff <= '0;
            end
            OP_STORE:   count_ff <= count_ff + CW'(1);
            OP_EXEC: begin
               reply_ff <= reply_in;
               step_ff  <= step_init;
               if (!body_empty) begin
                  case (b0_ff)
                     CMD_WRITE_MODE: begin
                        if ((len1 || len2) && sel_map < 8'd5) mode_ff <= sel_map[2:0];
                     end
                     CMD_PTT: begin
                        if (b1v == SUB_PTT && !len1) tx_ff <= b2v[0];
                     end
                     default: ;
                  endcase
               end
            end
            OP_FW_STEP, OP_BCD_STEP: step_ff <= step_ff - SW'(1);
            OP_CLAMP_HI: freq_ff <= (acc_ff > upper_ff) ? upper_ff : acc_ff;
            default: ;
         endcase
         if (cmd.op == OP_LOAD)  rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)    rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: rx_ff <= req_rx_byte;
         OP_STORE: begin
            if (count_ff == CW'(0)) b0_ff <= rx_ff;
            if (count_ff == CW'(1)) b1_ff <= rx_ff;
            if (count_ff == CW'(2)) b2_ff <= rx_ff;
         end
         OP_EXEC: begin
            acc_ff <= len_long ? upper_ff : '0;
            bin_ff <= freq_ff;
            bcd_ff <= '0;
         end
         OP_FW_STEP:  acc_ff <= acc_in;
         OP_BCD_STEP: begin
            bcd_ff <= {bcd_adj[4*BCD_DIGITS-2:0], bin_ff[FREQ_W-1]};
            bin_ff <= bin_ff << 1;
         end
         OP_CLAMP_LO: begin
            if (acc_ff < lower_ff) acc_ff <= lower_ff;
         end
         OP_LOAD: begin
            out_byte_ff <= byte_in;
            out_echo_ff <= is_echo_in;
            out_last_ff <= (cmd.emit_idx == stat.out_total - OUT_CNT_W'(1));
            out_freq_ff <= freq_ff;
            out_mode_ff <= mode_ff;
            out_ptt_ff  <= tx_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_STORE) body_mem[AW'(count_ff)] <= rx_ff;
      rd_ff <= body_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_is_echo     = out_echo_ff;
   assign rsp_freq_now    = out_freq_ff;
   assign rsp_mode_now    = out_mode_ff;
   assign rsp_ptt_on      = out_ptt_ff;

endmodule

FILE: rtl/rig_command_frame_responder_top.sv
// Serial command responder: each received byte (req beat) is optionally echoed, then parsed
// for a frame FE FE own_addr ctrl_addr body.. FD; at FD the command runs and any reply frame
// follows the echo on the rsp channel, last_of_run marking the final beat of each run.
// req_stall holds while an item is parsed, run or emitted, so no new byte is taken before
// the last one is through; rsp stalls hold the emit. A closing FD adds a command decode, a
// read-frequency command then 34 bit-serial binary-to-BCD shifts and the end check, a
// write-frequency command a body store walk of one step per BCD data byte (up to five), the
// end check and two clamps.
// Configuration writes are always ready and belong in idle time between items.
module rig_command_frame_responder_top
   import rcfr_pkg::*;
#(
   parameter int BODY_DEPTH = BODY_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_run,
   output logic                 rsp_is_echo,
   output logic [FREQ_W-1:0]    rsp_freq_now,
   output logic [2:0]           rsp_mode_now,
   output logic                 rsp_ptt_on,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FREQ_W-1:0]    csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   rcfr_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rcfr_dp #(
      .BODY_DEPTH (BODY_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_is_echo     (rsp_is_echo),
      .rsp_freq_now    (rsp_freq_now),
      .rsp_mode_now    (rsp_mode_now),
      .rsp_ptt_on      (rsp_ptt_on),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

endmodule
